FILE: hw/rtl/spwm_pkg.sv
package spwm_pkg;

	// Field widths that the register map and the result word fix.
	localparam int DUTY_BITS      = 17;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	// One per unit in 2^-16 steps, and the highest bus voltage at which a tick still gives no result.
	localparam logic [DUTY_BITS-1:0] UNIT_Q16    = 17'd65536;
	localparam logic [15:0]          BUS_MIN_CV  = 16'd100;
	localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PHASE_STEP    = 3'd0,
		REG_MOD_INDEX     = 3'd1,
		REG_ZERO_SEQ_EN   = 3'd2,
		REG_DUTY_FLOOR    = 3'd3,
		REG_DUTY_CEILING  = 3'd4,
		REG_TIMER_TOP     = 3'd5,
		REG_BUS_VOLTAGE   = 3'd6
	} reg_idx_t;

	// Configuration as the register file hands it to the datapath.
	typedef struct packed {
		logic [31:0]          phase_step;
		logic [DUTY_BITS-1:0] amplitude;
		logic                 zero_sequence_enable;
		logic [DUTY_BITS-1:0] duty_floor;
		logic [DUTY_BITS-1:0] duty_ceiling;
		logic [15:0]          timer_top;
		logic [15:0]          bus_voltage;
	} cfg_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROM,
		ST_SINE,
		ST_REF,
		ST_ZERO,
		ST_DUTY,
		ST_CMUL,
		ST_CMP,
		ST_OUT
	} state_t;

	// The three legs, worked one after another.
	typedef enum logic [1:0] {
		LEG_A,
		LEG_B,
		LEG_C
	} leg_t;

	// Divisors that take each odd Taylor term of the sine to the next one.
	localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210};

	// Sine in Q30 of an angle in [0, pi/2] given in Q30; used to build the table.
	function automatic logic signed [63:0] sin_q30(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		for (int n = 0; n < 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n[0] == 1'b0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		return sum;
	endfunction

endpackage

FILE: hw/rtl/spwm_ifs.sv
// Tick channel: one word per PWM update period.
interface spwm_tick_if;
	logic valid;
	logic ready;
	logic restart_phase;

	modport source (output valid, output restart_phase, input ready);
	modport sink (input valid, input restart_phase, output ready);
endinterface

// Result channel: compare values, duties, offset and angle of one update.
interface spwm_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] compare_a;
	logic [15:0] compare_b;
	logic [15:0] compare_c;
	logic [16:0] duty_a;
	logic [16:0] duty_b;
	logic [16:0] duty_c;
	logic signed [15:0] zero_offset;
	logic [31:0] angle_after;

	modport source (output valid, output compare_a, output compare_b, output compare_c,
		output duty_a, output duty_b, output duty_c, output zero_offset,
		output angle_after, input ready);
	modport sink (input valid, input compare_a, input compare_b, input compare_c,
		input duty_a, input duty_b, input duty_c, input zero_offset,
		input angle_after, output ready);
endinterface

// Configuration write channel.
interface spwm_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [spwm_pkg::CFG_INDEX_BITS-1:0] index;
	logic [spwm_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/spwm_cfg_regs.sv
module spwm_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	spwm_cfg_if.sink        cfg,
	output spwm_pkg::cfg_t  regs
);

	spwm_pkg::cfg_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Register file; an index beyond the map is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.phase_step           <= '0;
			regs_q.amplitude            <= '0;
			regs_q.zero_sequence_enable <= 1'b0;
			regs_q.duty_floor           <= '0;
			regs_q.duty_ceiling         <= spwm_pkg::UNIT_Q16;
			regs_q.timer_top            <= 16'hFFFF;
			regs_q.bus_voltage          <= '0;
		end else if (cfg.valid) begin
			case (spwm_pkg::reg_idx_t'(cfg.index))
				spwm_pkg::REG_PHASE_STEP: begin
					regs_q.phase_step <= cfg.data;
				end
				spwm_pkg::REG_MOD_INDEX: begin
					regs_q.amplitude <= cfg.data[spwm_pkg::DUTY_BITS-1:0];
				end
				spwm_pkg::REG_ZERO_SEQ_EN: begin
					regs_q.zero_sequence_enable <= cfg.data[0];
				end
				spwm_pkg::REG_DUTY_FLOOR: begin
					regs_q.duty_floor <= cfg.data[spwm_pkg::DUTY_BITS-1:0];
				end
				spwm_pkg::REG_DUTY_CEILING: begin
					regs_q.duty_ceiling <= cfg.data[spwm_pkg::DUTY_BITS-1:0];
				end
				spwm_pkg::REG_TIMER_TOP: begin
					regs_q.timer_top <= cfg.data[15:0];
				end
				spwm_pkg::REG_BUS_VOLTAGE: begin
					regs_q.bus_voltage <= cfg.data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/spwm_sine_rom.sv
module spwm_sine_rom #(
	parameter int ADDR_BITS = 10,
	parameter int SINE_BITS = 16
) (
	input  logic                        clk,
	input  logic [ADDR_BITS-1:0]        addr,
	output logic signed [SINE_BITS-1:0] data
);

	localparam int DEPTH     = 1 << ADDR_BITS;
	localparam int SINE_FRAC = SINE_BITS - 1;

	typedef logic signed [SINE_BITS-1:0] rom_t [DEPTH];

	// Full-turn table built from the quarter wave, rounded and saturated.
	function automatic rom_t build_table();
		rom_t               tbl;
		logic [63:0]        quarter;
		logic [63:0]        q;
		logic [63:0]        r;
		logic [63:0]        x;
		logic signed [63:0] s;
		logic signed [63:0] maxcode;
		quarter = 64'd1 << (ADDR_BITS - 2);
		maxcode = (64'sd1 <<< SINE_FRAC) - 64'sd1;
		for (int k = 0; k < DEPTH; k++) begin
			q = (64'(k) >> (ADDR_BITS - 2)) & 64'd3;
			r = 64'(k) & (quarter - 64'd1);
			if (q[0]) begin
				r = quarter - r;
			end
			x = (r * spwm_pkg::HALF_PI_Q30) >> (ADDR_BITS - 2);
			s = spwm_pkg::sin_q30(x);
			if (s < 0) begin
				s = 64'sd0;
			end
			s = (s + (64'sd1 <<< (29 - SINE_FRAC))) >>> (30 - SINE_FRAC);
			if (s > maxcode) begin
				s = maxcode;
			end
			tbl[k] = SINE_BITS'((q >= 64'd2) ? -s : s);
		end
		return tbl;
	endfunction

	localparam rom_t SINE_TABLE = build_table();

	// Registered read port.
	always_ff @(posedge clk) begin
		data <= SINE_TABLE[addr];
	end

endmodule

FILE: hw/rtl/spwm_mul.sv
module spwm_mul #(
	parameter int A_BITS = 17,
	parameter int B_BITS = 17
) (
	input  logic                     clk,
	input  logic [A_BITS-1:0]        a,
	input  logic [B_BITS-1:0]        b,
	output logic [A_BITS+B_BITS-1:0] prod
);

	localparam int PROD_BITS = A_BITS + B_BITS;

	logic [PROD_BITS-1:0] prod_s1;

	// Unsigned multiply with the product registered.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_BITS'(a) * PROD_BITS'(b);
	end

	assign prod = prod_s1;

endmodule

FILE: hw/rtl/three_phase_sine_pwm_generator_core.sv
// Three-phase sine PWM generator. Each word on the tick channel is one PWM update period; it
// yields one result word with the three timer compare values, the three clamped Q1.16
// duties, the injected min-max common-mode offset and the electrical angle after the advance.
// When the bus voltage register reads 1 V or less a tick gives no result, the angle holds,
// and the block is ready again in the next cycle; restart_phase still clears the angle. A
// tick that produces output keeps the block busy while it steps through ROM, SINE and REF
// per leg, ZERO, DUTY, CMUL and CMP per leg, and OUT; a new tick is taken back in IDLE. The
// order comes from the single multiplier and the single sine table port, which are passed
// three times for the references (table read, multiply, round) and three times for the
// compare values (duty, multiply, round and cap), plus a step for the offset and one to
// load the result. A result that has not been taken holds the block at its last step.
// Configuration writes are always taken and must only be issued while the block is idle.
module three_phase_sine_pwm_generator_core #(
	parameter int ANGLE_BITS           = 32,
	parameter int SINE_BITS            = 16,
	parameter int SINE_TABLE_ADDR_BITS = 10,
	parameter int COMPARE_BITS         = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	spwm_cfg_if.sink      cfg,
	spwm_tick_if.sink     tick,
	spwm_result_if.source result
);

	localparam int DB         = spwm_pkg::DUTY_BITS;
	localparam int SINE_FRAC  = SINE_BITS - 1;
	localparam int MUL_B_BITS = (SINE_BITS - 1 > COMPARE_BITS + 1) ? SINE_BITS - 1
		: COMPARE_BITS + 1;
	localparam int PROD_BITS  = DB + MUL_B_BITS;
	localparam logic [ANGLE_BITS-1:0] THIRD_TURN =
		ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 64'd3);
	localparam logic [PROD_BITS:0] REF_HALF = (PROD_BITS + 1)'(1) << (SINE_FRAC - 1);
	localparam logic [PROD_BITS:0] CMP_HALF = (PROD_BITS + 1)'(32768);

	spwm_pkg::cfg_t   regs;
	spwm_pkg::state_t state_q;
	spwm_pkg::state_t state_d;
	spwm_pkg::leg_t   leg_q;

	logic [ANGLE_BITS-1:0]           angle_q;
	logic [ANGLE_BITS-1:0]           leg_angle;
	logic [SINE_TABLE_ADDR_BITS-1:0] rom_addr;
	logic signed [SINE_BITS-1:0]     rom_data;
	logic [SINE_BITS-2:0]            sine_mag;
	logic                            sine_neg_q;
	logic [DB-1:0]                   mul_a;
	logic [MUL_B_BITS-1:0]           mul_b;
	logic [PROD_BITS-1:0]            prod;

	logic signed [DB:0]         ref_q [3];
	logic signed [15:0]         z_q;
	logic [DB-1:0]              duty_q [3];
	logic [COMPARE_BITS-1:0]    cmp_q [3];

	logic                       out_valid_q;
	logic [15:0]                compare_a_q;
	logic [15:0]                compare_b_q;
	logic [15:0]                compare_c_q;
	logic [DB-1:0]              duty_a_q;
	logic [DB-1:0]              duty_b_q;
	logic [DB-1:0]              duty_c_q;
	logic signed [15:0]         zero_offset_q;
	logic [31:0]                angle_after_q;

	logic                       tick_take;
	logic                       bus_low;
	logic                       out_free;
	logic                       load_out;
	logic                       last_leg;
	logic [DB-1:0]              m_eff;
	logic [DB-1:0]              duty_lo;
	logic [DB-1:0]              duty_hi;
	logic [COMPARE_BITS-1:0]    top_eff;
	logic [ANGLE_BITS-1:0]      angle_next;

	logic [PROD_BITS:0]         ref_rnd;
	logic [DB-1:0]              ref_mag;
	logic signed [DB:0]         ref_val;
	logic signed [DB:0]         vmin;
	logic signed [DB:0]         vmax;
	logic signed [DB+1:0]       zsum;
	logic signed [DB+1:0]       zquart;
	logic signed [15:0]         z_val;
	logic signed [DB+2:0]       cmd_raw;
	logic signed [DB:0]         cmd;
	logic [DB+1:0]              dsum;
	logic [DB-1:0]              duty_raw;
	logic [DB-1:0]              duty_val;
	logic [PROD_BITS:0]         cmp_rnd;
	logic [COMPARE_BITS-1:0]    cmp_val;

	spwm_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	spwm_sine_rom #(
		.ADDR_BITS (SINE_TABLE_ADDR_BITS),
		.SINE_BITS (SINE_BITS)
	) u_sine_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	spwm_mul #(
		.A_BITS (DB),
		.B_BITS (MUL_B_BITS)
	) u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Effective settings: index, floor and ceiling saturate at one; top is cut to the timer.
	assign m_eff   = (regs.amplitude > spwm_pkg::UNIT_Q16) ? spwm_pkg::UNIT_Q16
		: regs.amplitude;
	assign duty_lo = (regs.duty_floor > spwm_pkg::UNIT_Q16) ? spwm_pkg::UNIT_Q16
		: regs.duty_floor;
	assign duty_hi = (regs.duty_ceiling > spwm_pkg::UNIT_Q16) ? spwm_pkg::UNIT_Q16
		: regs.duty_ceiling;
	assign top_eff = COMPARE_BITS'(regs.timer_top);
	assign bus_low = (regs.bus_voltage <= spwm_pkg::BUS_MIN_CV);
	assign out_free = !out_valid_q || result.ready;
	assign tick_take = tick.valid && tick.ready;
	assign last_leg = (leg_q == spwm_pkg::LEG_C);
	assign angle_next = angle_q + regs.phase_step[ANGLE_BITS-1:0];

	// Table address of the current leg: the angle, a third turn behind, a third turn ahead.
	always_comb begin
		case (leg_q)
			spwm_pkg::LEG_A: leg_angle = angle_q;
			spwm_pkg::LEG_B: leg_angle = angle_q - THIRD_TURN;
			default:         leg_angle = angle_q + THIRD_TURN;
		endcase
	end
	assign rom_addr = leg_angle[ANGLE_BITS-1 -: SINE_TABLE_ADDR_BITS];
	assign sine_mag = rom_data[SINE_BITS-1] ? (SINE_BITS - 1)'(-rom_data)
		: (SINE_BITS - 1)'(rom_data);

	// Reference rounding, half away from zero on the magnitude.
	assign ref_rnd = {1'b0, prod} + REF_HALF;
	assign ref_mag = DB'(ref_rnd >> SINE_FRAC);
	assign ref_val = sine_neg_q ? -$signed({1'b0, ref_mag}) : $signed({1'b0, ref_mag});

	// Min-max offset: a quarter of vmin plus vmax, truncated toward zero, saturated; zero when disabled.
	always_comb begin
		vmin = ref_q[0];
		vmax = ref_q[0];
		for (int i = 1; i < 3; i++) begin
			if (ref_q[i] < vmin) begin
				vmin = ref_q[i];
			end
			if (ref_q[i] > vmax) begin
				vmax = ref_q[i];
			end
		end
		zsum = (DB + 2)'(vmin) + (DB + 2)'(vmax);
		if (zsum < 0) begin
			zquart = (zsum + (DB + 2)'(3)) >>> 2;
		end else begin
			zquart = zsum >>> 2;
		end
		if (!regs.zero_sequence_enable) begin
			z_val = '0;
		end else if (zquart > (DB + 2)'(32767)) begin
			z_val = 16'sd32767;
		end else if (zquart < -(DB + 2)'(32768)) begin
			z_val = -16'sd32768;
		end else begin
			z_val = 16'(zquart);
		end
	end

	// Duty of the current leg: command clamp, (1+v)/2, then floor before ceiling.
	always_comb begin
		cmd_raw = (DB + 3)'(ref_q[leg_q]) - ((DB + 3)'(z_q) <<< 1);
		if (cmd_raw > (DB + 3)'(65536)) begin
			cmd = (DB + 1)'(65536);
		end else if (cmd_raw < -(DB + 3)'(65536)) begin
			cmd = -(DB + 1)'(65536);
		end else begin
			cmd = (DB + 1)'(cmd_raw);
		end
		dsum     = (DB + 2)'(spwm_pkg::UNIT_Q16) + (DB + 2)'(unsigned'(cmd))
			+ (DB + 2)'(1);
		duty_raw = dsum[DB:1];
		if (duty_raw < duty_lo) begin
			duty_val = duty_lo;
		end else if (duty_raw > duty_hi) begin
			duty_val = duty_hi;
		end else begin
			duty_val = duty_raw;
		end
	end

	// Compare value: rounded duty times period, capped at top.
	assign cmp_rnd = ({1'b0, prod} + CMP_HALF) >> 16;
	assign cmp_val = (cmp_rnd > (PROD_BITS + 1)'(top_eff)) ? top_eff
		: COMPARE_BITS'(cmp_rnd);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			spwm_pkg::ST_IDLE: begin
				if (tick.valid && !bus_low) begin
					state_d = spwm_pkg::ST_ROM;
				end
			end
			spwm_pkg::ST_ROM:  state_d = spwm_pkg::ST_SINE;
			spwm_pkg::ST_SINE: state_d = spwm_pkg::ST_REF;
			spwm_pkg::ST_REF: begin
				state_d = last_leg ? spwm_pkg::ST_ZERO : spwm_pkg::ST_ROM;
			end
			spwm_pkg::ST_ZERO: state_d = spwm_pkg::ST_DUTY;
			spwm_pkg::ST_DUTY: state_d = spwm_pkg::ST_CMUL;
			spwm_pkg::ST_CMUL: state_d = spwm_pkg::ST_CMP;
			spwm_pkg::ST_CMP: begin
				state_d = last_leg ? spwm_pkg::ST_OUT : spwm_pkg::ST_DUTY;
			end
			spwm_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = spwm_pkg::ST_IDLE;
				end
			end
			default: state_d = spwm_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and the operands of the shared multiplier.
	always_comb begin
		tick.ready = 1'b0;
		load_out   = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		case (state_q)
			spwm_pkg::ST_IDLE: begin
				tick.ready = 1'b1;
			end
			spwm_pkg::ST_SINE: begin
				mul_a = m_eff;
				mul_b = MUL_B_BITS'(sine_mag);
			end
			spwm_pkg::ST_CMUL: begin
				mul_a = duty_q[leg_q];
				mul_b = MUL_B_BITS'(top_eff) + MUL_B_BITS'(1);
			end
			spwm_pkg::ST_OUT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control state: sequencer, leg counter, angle and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= spwm_pkg::ST_IDLE;
			leg_q       <= spwm_pkg::LEG_A;
			angle_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick_take) begin
				leg_q <= spwm_pkg::LEG_A;
				if (tick.restart_phase) begin
					angle_q <= '0;
				end
			end else if (state_q == spwm_pkg::ST_REF) begin
				leg_q <= last_leg ? spwm_pkg::LEG_A : spwm_pkg::leg_t'(leg_q + 2'd1);
			end else if (state_q == spwm_pkg::ST_CMP && !last_leg) begin
				leg_q <= spwm_pkg::leg_t'(leg_q + 2'd1);
			end
			if (load_out) begin
				angle_q     <= angle_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (state_q == spwm_pkg::ST_SINE) begin
			sine_neg_q <= rom_data[SINE_BITS-1];
		end
		if (state_q == spwm_pkg::ST_REF) begin
			ref_q[leg_q] <= ref_val;
		end
		if (state_q == spwm_pkg::ST_ZERO) begin
			z_q <= z_val;
		end
		if (state_q == spwm_pkg::ST_DUTY) begin
			duty_q[leg_q] <= duty_val;
		end
		if (state_q == spwm_pkg::ST_CMP) begin
			cmp_q[leg_q] <= cmp_val;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			compare_a_q   <= 16'(cmp_q[0]);
			compare_b_q   <= 16'(cmp_q[1]);
			compare_c_q   <= 16'(cmp_q[2]);
			duty_a_q      <= duty_q[0];
			duty_b_q      <= duty_q[1];
			duty_c_q      <= duty_q[2];
			zero_offset_q <= z_q;
			angle_after_q <= 32'(angle_next);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.compare_a   = compare_a_q;
	assign result.compare_b   = compare_b_q;
	assign result.compare_c   = compare_c_q;
	assign result.duty_a      = duty_a_q;
	assign result.duty_b      = duty_b_q;
	assign result.duty_c      = duty_c_q;
	assign result.zero_offset = zero_offset_q;
	assign result.angle_after = angle_after_q;

endmodule

FILE: hw/rtl/spwm_checker.sv
module spwm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        tick_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [16:0] duty_a,
	input logic [16:0] duty_b,
	input logic [16:0] duty_c,
	input logic [31:0] angle_after
);

	// A result word stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
	else $error("result word dropped before it was taken");

	// A stalled result word keeps its angle and its leg A duty.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(angle_after) && $stable(duty_a))
	else $error("result payload changed while stalled");

	// A new result only appears at the end of an update, while ticks are held off.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(tick_ready))
	else $error("result appeared while the block was idle");

	// Duties never exceed one.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> duty_a <= 17'd65536 && duty_b <= 17'd65536 && duty_c <= 17'd65536)
	else $error("duty above one");

endmodule

bind three_phase_sine_pwm_generator_core spwm_checker u_spwm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.duty_a       (result.duty_a),
	.duty_b       (result.duty_b),
	.duty_c       (result.duty_c),
	.angle_after  (result.angle_after)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int LUT_ADDR_BITS = 10;
	localparam int LUT_SIZE      = 1 << LUT_ADDR_BITS;
	localparam int QUARTER_SHIFT = LUT_ADDR_BITS - 2;

	// Index past the end of the register map; writes to it must change nothing.
	localparam logic [spwm_pkg::CFG_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;

	localparam longint      ONE_Q16          = 65536;
	localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [31:0] THIRD_TURN       = 32'd1431655765;
	localparam logic [31:0] LUT_STEP         = 32'h0040_0000;
	localparam int          SETTLE_CYCLES    = 40;
	localparam int          RANDOM_PHASES    = 16;
	localparam int          UPDATES_PER_PHASE = 66;
	localparam int          LOW_BUS_PHASE    = 5;
	localparam int          LOW_BUS_TICKS    = 20;
	localparam int          MAX_PRINTED      = 100;

	// One expected result word.
	typedef struct {
		logic [15:0]        compare_a;
		logic [15:0]        compare_b;
		logic [15:0]        compare_c;
		logic [16:0]        duty_a;
		logic [16:0]        duty_b;
		logic [16:0]        duty_c;
		logic signed [15:0] zero_offset;
		logic [31:0]        angle_after;
	} pwm_update_t;

	logic clk;
	logic arst_n;

	spwm_cfg_if    cfg_bus ();
	spwm_tick_if   tick_bus ();
	spwm_result_if res_bus ();

	three_phase_sine_pwm_generator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.tick   (tick_bus),
		.result (res_bus)
	);

	// Shadow of the register file, the electrical angle and the updates still owed.
	spwm_pkg::cfg_t shadow_cfg;
	logic [31:0]    angle_acc;
	longint         sine_lut [LUT_SIZE];
	pwm_update_t    expected_updates [$];
	int             updates_predicted;
	int             mismatches;

	// Idle control of both sides, in percent of cycles, and the long receiver hold-off.
	int src_gap_pct;
	int sink_stall_pct;
	int hold_cycles;
	int sink_gap;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#7_000_000;
		$display("status: fail");
		$finish;
	end

	// Sine of an angle in [0, pi/2], both in Q30, by odd Taylor terms up to degree 15.
	function automatic longint taylor_sine_q30(input logic [63:0] x);
		logic [63:0] x_sq;
		logic [63:0] term;
		longint      acc;
		x_sq = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return acc;
	endfunction

	// Table entry k in Q1.15: quarter-wave symmetry, rounded and saturated.
	function automatic longint lut_entry(input int k);
		int          quadrant;
		int          offset;
		logic [63:0] x;
		longint      s;
		quadrant = (k >> QUARTER_SHIFT) & 3;
		offset   = k & ((1 << QUARTER_SHIFT) - 1);
		if (quadrant % 2 == 1) begin
			offset = (1 << QUARTER_SHIFT) - offset;
		end
		x = (64'(offset) * QUARTER_TURN_Q30) >> QUARTER_SHIFT;
		s = taylor_sine_q30(x);
		if (s < 0) begin
			s = 0;
		end
		s = (s + 16384) >>> 15;
		if (s > 32767) begin
			s = 32767;
		end
		return (quadrant >= 2) ? -s : s;
	endfunction

	function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
		if (x < lo) begin
			return lo;
		end
		if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	// Leg reference in 2^-16 units: table value times the index, rounded away from zero.
	function automatic longint leg_reference(input logic [31:0] angle, input longint m);
		longint prod;
		longint mag;
		longint r;
		prod = m * sine_lut[angle[31:32-LUT_ADDR_BITS]];
		mag  = (prod < 0) ? -prod : prod;
		r    = (mag + 16384) >>> 15;
		return (prod < 0) ? -r : r;
	endfunction

	// Works out one tick; returns 1 when the tick yields a result word.
	function automatic bit predict_update(input logic restart, output pwm_update_t upd);
		longint m;
		longint lo;
		longint hi;
		longint top;
		longint z;
		longint vmin;
		longint vmax;
		longint cmd;
		longint legs [3];
		longint duty [3];
		longint cmp [3];
		upd = '{default: '0};
		if (restart) begin
			angle_acc = '0;
		end
		if (shadow_cfg.bus_voltage <= spwm_pkg::BUS_MIN_CV) begin
			return 1'b0;
		end
		m = (shadow_cfg.amplitude > spwm_pkg::UNIT_Q16) ? ONE_Q16
			: longint'(shadow_cfg.amplitude);
		legs[0] = leg_reference(angle_acc, m);
		legs[1] = leg_reference(angle_acc - THIRD_TURN, m);
		legs[2] = leg_reference(angle_acc + THIRD_TURN, m);

		// Min-max common-mode offset, truncated toward zero.
		z = 0;
		if (shadow_cfg.zero_sequence_enable) begin
			vmin = legs[0];
			vmax = legs[0];
			for (int i = 1; i < 3; i++) begin
				if (legs[i] < vmin) begin
					vmin = legs[i];
				end
				if (legs[i] > vmax) begin
					vmax = legs[i];
				end
			end
			z = clamp_to((vmin + vmax) / 4, -32768, 32767);
		end

		lo  = (shadow_cfg.duty_floor > spwm_pkg::UNIT_Q16) ? ONE_Q16
			: longint'(shadow_cfg.duty_floor);
		hi  = (shadow_cfg.duty_ceiling > spwm_pkg::UNIT_Q16) ? ONE_Q16
			: longint'(shadow_cfg.duty_ceiling);
		top = longint'(shadow_cfg.timer_top);

		// Command, duty and compare value of each leg.
		for (int i = 0; i < 3; i++) begin
			cmd     = clamp_to(legs[i] - 2 * z, -ONE_Q16, ONE_Q16);
			duty[i] = clamp_to((ONE_Q16 + cmd + 1) >>> 1, lo, hi);
			cmp[i]  = (duty[i] * (top + 1) + 32768) >>> 16;
			if (cmp[i] > top) begin
				cmp[i] = top;
			end
		end
		upd.compare_a   = 16'(cmp[0]);
		upd.compare_b   = 16'(cmp[1]);
		upd.compare_c   = 16'(cmp[2]);
		upd.duty_a      = 17'(duty[0]);
		upd.duty_b      = 17'(duty[1]);
		upd.duty_c      = 17'(duty[2]);
		upd.zero_offset = 16'(z);
		angle_acc       = angle_acc + shadow_cfg.phase_step;
		upd.angle_after = angle_acc;
		return 1'b1;
	endfunction

	// Mostly no gap; short gaps are common and long ones rare.
	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct) begin
			return 0;
		end
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_PRINTED) begin
			$display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	// Writes one register word and mirrors it in the shadow.
	task automatic write_reg(input logic [spwm_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [31:0] value);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data  = value;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			spwm_pkg::REG_PHASE_STEP: begin
				shadow_cfg.phase_step = value;
			end
			spwm_pkg::REG_MOD_INDEX: begin
				shadow_cfg.amplitude = value[16:0];
			end
			spwm_pkg::REG_ZERO_SEQ_EN: begin
				shadow_cfg.zero_sequence_enable = value[0];
			end
			spwm_pkg::REG_DUTY_FLOOR: begin
				shadow_cfg.duty_floor = value[16:0];
			end
			spwm_pkg::REG_DUTY_CEILING: begin
				shadow_cfg.duty_ceiling = value[16:0];
			end
			spwm_pkg::REG_TIMER_TOP: begin
				shadow_cfg.timer_top = value[15:0];
			end
			spwm_pkg::REG_BUS_VOLTAGE: begin
				shadow_cfg.bus_voltage = value[15:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Sometimes sets the unused upper data bits, which the register must drop.
	function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
		if ($urandom_range(0, 3) == 0) begin
			return value | ($urandom() << width);
		end
		return value;
	endfunction

	task automatic apply_config(input spwm_pkg::cfg_t c);
		write_reg(spwm_pkg::REG_PHASE_STEP, c.phase_step);
		write_reg(spwm_pkg::REG_MOD_INDEX, with_junk(32'(c.amplitude), 17));
		write_reg(spwm_pkg::REG_ZERO_SEQ_EN, with_junk(32'(c.zero_sequence_enable), 1));
		write_reg(spwm_pkg::REG_DUTY_FLOOR, with_junk(32'(c.duty_floor), 17));
		write_reg(spwm_pkg::REG_DUTY_CEILING, with_junk(32'(c.duty_ceiling), 17));
		write_reg(spwm_pkg::REG_TIMER_TOP, with_junk(32'(c.timer_top), 16));
		write_reg(spwm_pkg::REG_BUS_VOLTAGE, with_junk(32'(c.bus_voltage), 16));
	endtask

	// Offers one tick word, waits for it to be taken and records what it must yield.
	task automatic send_tick(input logic restart);
		int          gap;
		pwm_update_t upd;
		gap = pick_gap(src_gap_pct);
		@(negedge clk);
		if (gap > 0) begin
			tick_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_bus.valid         = 1'b1;
		tick_bus.restart_phase = restart;
		do @(posedge clk); while (!tick_bus.ready);
		if (predict_update(restart, upd)) begin
			expected_updates.push_back(upd);
			updates_predicted++;
		end
	endtask

	// Stops offering ticks, waits for every owed result and lets the datapath go quiet.
	task automatic drain();
		@(negedge clk);
		tick_bus.valid = 1'b0;
		while (expected_updates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic spwm_pkg::cfg_t random_config();
		spwm_pkg::cfg_t c;
		case ($urandom_range(0, 9))
			0: c.phase_step = '0;
			1: c.phase_step = '1;
			2: c.phase_step = LUT_STEP * $urandom_range(1, 300);
			3, 4, 5: c.phase_step = $urandom_range(0, 32'h0080_0000);
			default: c.phase_step = $urandom();
		endcase
		case ($urandom_range(0, 19))
			0, 1: c.amplitude = '0;
			2, 3, 4: c.amplitude = spwm_pkg::UNIT_Q16;
			5, 6, 7: c.amplitude = 17'($urandom_range(65537, 131071));
			default: c.amplitude = 17'($urandom_range(0, 65536));
		endcase
		c.zero_sequence_enable = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: c.duty_floor = '0;
			5, 6, 7: c.duty_floor = 17'($urandom_range(0, 20000));
			default: c.duty_floor = 17'($urandom_range(0, 131071));
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: c.duty_ceiling = spwm_pkg::UNIT_Q16;
			5, 6, 7: c.duty_ceiling = 17'($urandom_range(45000, 65536));
			default: c.duty_ceiling = 17'($urandom_range(0, 131071));
		endcase
		case ($urandom_range(0, 9))
			0: c.timer_top = '0;
			1, 2: c.timer_top = '1;
			3, 4, 5: c.timer_top = 16'($urandom_range(100, 5000));
			default: c.timer_top = 16'($urandom_range(0, 65535));
		endcase
		c.bus_voltage = 16'($urandom_range(101, 65535));
		return c;
	endfunction

	// Result checker: each accepted word against the oldest expectation.
	always @(posedge clk) begin : check_updates
		pwm_update_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_updates.size() == 0) begin
				report_mismatch("result word with nothing expected", res_bus.angle_after, 0);
			end else begin
				want = expected_updates.pop_front();
				if (res_bus.compare_a !== want.compare_a)
					report_mismatch("compare_a", res_bus.compare_a, want.compare_a);
				if (res_bus.compare_b !== want.compare_b)
					report_mismatch("compare_b", res_bus.compare_b, want.compare_b);
				if (res_bus.compare_c !== want.compare_c)
					report_mismatch("compare_c", res_bus.compare_c, want.compare_c);
				if (res_bus.duty_a !== want.duty_a)
					report_mismatch("duty_a", res_bus.duty_a, want.duty_a);
				if (res_bus.duty_b !== want.duty_b)
					report_mismatch("duty_b", res_bus.duty_b, want.duty_b);
				if (res_bus.duty_c !== want.duty_c)
					report_mismatch("duty_c", res_bus.duty_c, want.duty_c);
				if (res_bus.zero_offset !== want.zero_offset)
					report_mismatch("zero_offset", res_bus.zero_offset, want.zero_offset);
				if (res_bus.angle_after !== want.angle_after)
					report_mismatch("angle_after", res_bus.angle_after, want.angle_after);
			end
		end
	end

	// Result receiver: random stalls, plus the long hold-off when one is requested.
	initial begin
		res_bus.ready = 1'b0;
		sink_gap      = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_bus.ready = 1'b0;
				hold_cycles--;
			end else if (sink_gap > 0) begin
				res_bus.ready = 1'b0;
				sink_gap--;
			end else begin
				res_bus.ready = 1'b1;
				sink_gap      = pick_gap(sink_stall_pct);
			end
		end
	end

	// Registers at their reset values: a dead bus gives nothing, then a live bus at zero
	// amplitude gives half duty on every leg.
	task automatic test_reset_defaults();
		send_tick(1'b0);
		send_tick(1'b1);
		drain();
		write_reg(spwm_pkg::REG_BUS_VOLTAGE, 32'd101);
		send_tick(1'b0);
		send_tick(1'b1);
		drain();
	endtask

	task automatic test_directed_corners();
		spwm_pkg::cfg_t c;

		// Full amplitude, one table entry per tick from a cleared angle.
		c = '{phase_step: LUT_STEP, amplitude: spwm_pkg::UNIT_Q16, zero_sequence_enable: 1'b0,
			duty_floor: '0, duty_ceiling: spwm_pkg::UNIT_Q16, timer_top: '1, bus_voltage: '1};
		apply_config(c);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		drain();

		// Index and floor above one, ceiling at zero so floor above ceiling, zero timer top,
		// largest step and injection on.
		c = '{phase_step: '1, amplitude: '1, zero_sequence_enable: 1'b1,
			duty_floor: '1, duty_ceiling: '0, timer_top: '0, bus_voltage: 16'd4800};
		apply_config(c);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain();

		// Floor above ceiling inside the legal range, timer top of one.
		c = '{phase_step: 32'h5555_5555, amplitude: spwm_pkg::UNIT_Q16,
			zero_sequence_enable: 1'b1, duty_floor: 17'd40000, duty_ceiling: 17'd20000,
			timer_top: 16'd1, bus_voltage: 16'd101};
		apply_config(c);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		drain();

		// Bus at exactly 1 V: no word, angle holds, but a restart still clears it.
		write_reg(spwm_pkg::REG_BUS_VOLTAGE, 32'd100);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		drain();
		write_reg(spwm_pkg::REG_BUS_VOLTAGE, 32'd101);
		send_tick(1'b0);
		drain();

		// A write past the register map must leave the setup alone.
		write_reg(REG_UNMAPPED, $urandom());
		send_tick(1'b0);
		drain();

		// Half-turn step, amplitude just under one, duties limited only by the rails.
		c = '{phase_step: 32'h8000_0000, amplitude: 17'd65535, zero_sequence_enable: 1'b0,
			duty_floor: '0, duty_ceiling: spwm_pkg::UNIT_Q16, timer_top: '1,
			bus_voltage: 16'd32768};
		apply_config(c);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		drain();
	endtask

	// The receiver holds off while ticks keep coming, so the block has to stall its input.
	task automatic test_result_backpressure();
		apply_config(random_config());
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		@(posedge clk);
		hold_cycles = 400;
		for (int i = 0; i < 16; i++) begin
			send_tick(i == 0);
		end
		drain();
	endtask

	// Random setups in phases, each run with its own idle pattern; one phase has a dead bus.
	task automatic test_random_updates();
		int phase_start;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p % 4 == 0) begin
				src_gap_pct    = 0;
				sink_stall_pct = 0;
			end else begin
				src_gap_pct    = $urandom_range(10, 50);
				sink_stall_pct = $urandom_range(10, 50);
			end
			if (p == LOW_BUS_PHASE) begin
				apply_config(random_config());
				write_reg(spwm_pkg::REG_BUS_VOLTAGE, $urandom_range(0, 100));
				for (int i = 0; i < LOW_BUS_TICKS; i++) begin
					send_tick($urandom_range(0, 9) == 0);
				end
			end else begin
				apply_config(random_config());
				phase_start = updates_predicted;
				while (updates_predicted - phase_start < UPDATES_PER_PHASE) begin
					send_tick($urandom_range(0, 9) == 0);
				end
			end
			drain();
		end
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.index          = '0;
		cfg_bus.data           = '0;
		tick_bus.valid         = 1'b0;
		tick_bus.restart_phase = 1'b0;
		src_gap_pct            = 30;
		sink_stall_pct         = 30;
		hold_cycles            = 0;
		mismatches             = 0;
		updates_predicted      = 0;
		angle_acc              = '0;
		shadow_cfg = '{phase_step: '0, amplitude: '0, zero_sequence_enable: 1'b0,
			duty_floor: '0, duty_ceiling: spwm_pkg::UNIT_Q16, timer_top: '1, bus_voltage: '0};
		for (int k = 0; k < LUT_SIZE; k++) begin
			sine_lut[k] = lut_entry(k);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_directed_corners();
		test_result_backpressure();
		test_random_updates();

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
